[hw/rtl/three_digit_segment_led_serializer_assert.svh]
// Assertion helpers shared by the serializer RTL.
`ifndef THREE_DIGIT_SEGMENT_LED_SERIALIZER_ASSERT_SVH
`define THREE_DIGIT_SEGMENT_LED_SERIALIZER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TDSLS_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdsls same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TDSLS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdsls next-cycle check failed");

`endif

[hw/rtl/tdsls_pkg.sv]
`timescale 1ns / 1ps

package tdsls_pkg;

  localparam int WORD_W   = 32;
  localparam int CNT_W    = 5;
  localparam int DIGIT_W  = 4;
  localparam int PAT_W    = 16;

  // floor(n / 10) == (n * DIV10_MUL) >> DIV10_SHIFT, exact for n < 2**18
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int          DIV10_SHIFT = 19;

  localparam logic [CNT_W-1:0] LAST_BIT = 5'd31;

  localparam int QUEUE_DEPTH = 2;

  // Split-display pattern: DP,C,D,E in bits 15..12, G,F,A,B in bits 3..0
  function automatic logic [PAT_W-1:0] seg_split(input logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] r;
    case (d)
      4'd0:    r = 16'h7007;
      4'd1:    r = 16'h4001;
      4'd2:    r = 16'h300B;
      4'd3:    r = 16'h600B;
      4'd4:    r = 16'h400D;
      4'd5:    r = 16'h600E;
      4'd6:    r = 16'h700E;
      4'd7:    r = 16'h4003;
      4'd8:    r = 16'h700F;
      4'd9:    r = 16'h600F;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // Middle display pattern: DP,C,D,E,G,F,A,B in bits 11..4
  function automatic logic [PAT_W-1:0] seg_mid(input logic [DIGIT_W-1:0] d);
    logic [PAT_W-1:0] r;
    case (d)
      4'd0:    r = 16'h0770;
      4'd1:    r = 16'h0410;
      4'd2:    r = 16'h03B0;
      4'd3:    r = 16'h06B0;
      4'd4:    r = 16'h04D0;
      4'd5:    r = 16'h06E0;
      4'd6:    r = 16'h07E0;
      4'd7:    r = 16'h0430;
      4'd8:    r = 16'h07F0;
      4'd9:    r = 16'h06F0;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

  // Bar pattern in the upper half-word: levels above eight light nothing
  function automatic logic [PAT_W-1:0] bar_pat(input logic [3:0] lvl);
    logic [PAT_W-1:0] r;
    case (lvl)
      4'd0:    r = 16'h0000;
      4'd1:    r = 16'h0100;
      4'd2:    r = 16'h0300;
      4'd3:    r = 16'h0700;
      4'd4:    r = 16'h0F00;
      4'd5:    r = 16'h0F80;
      4'd6:    r = 16'h0FC0;
      4'd7:    r = 16'h0FE0;
      4'd8:    r = 16'h0FF0;
      default: r = 16'h0000;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/tdsls_front.sv]
`timescale 1ns / 1ps

module tdsls_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [15:0]                  in_value,
  input  logic [3:0]                   in_level,
  output logic                         word_valid,
  input  logic                         word_ready,
  output logic [tdsls_pkg::WORD_W-1:0] word
);

  logic        v1, v2, v3;
  logic        rdy1, rdy2, rdy3;

  logic [15:0] num1;
  logic [3:0]  lvl1, lvl2, lvl3;
  logic [12:0] q10_1, q10_2;
  logic [3:0]  units2, units3, tens3;
  logic [9:0]  q100_2, q100_3;
  logic [6:0]  q1000_3;

  logic [31:0] prod1, prod2, prod3;
  logic [15:0] rem1;
  logic [12:0] rem2;
  logic [9:0]  rem3;
  logic [3:0]  hund;

  // stall chain: a stage loads when it is empty or its content moves on
  assign rdy3     = !v3 || word_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  assign prod1 = {16'd0, in_value} * {16'd0, tdsls_pkg::DIV10_MUL};
  assign prod2 = {19'd0, q10_1} * {16'd0, tdsls_pkg::DIV10_MUL};
  assign prod3 = {22'd0, q100_2} * {16'd0, tdsls_pkg::DIV10_MUL};

  assign rem1 = num1 - (({3'd0, q10_1} << 3) + ({3'd0, q10_1} << 1));
  assign rem2 = q10_2 - (({3'd0, q100_2} << 3) + ({3'd0, q100_2} << 1));
  assign rem3 = q100_3 - (({3'd0, q1000_3} << 3) + ({3'd0, q1000_3} << 1));
  assign hund = rem3[3:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      num1  <= in_value;
      lvl1  <= in_level;
      q10_1 <= prod1[31:19];
    end
    if (rdy2 && v1) begin
      lvl2   <= lvl1;
      q10_2  <= q10_1;
      units2 <= rem1[3:0];
      q100_2 <= prod2[28:19];
    end
    if (rdy3 && v2) begin
      lvl3    <= lvl2;
      units3  <= units2;
      tens3   <= rem2[3:0];
      q100_3  <= q100_2;
      q1000_3 <= prod3[25:19];
    end
  end

  assign word_valid = v3;
  assign word = {(tdsls_pkg::seg_split(hund) | tdsls_pkg::bar_pat(lvl3)), 16'd0}
              | {16'd0, tdsls_pkg::seg_mid(tens3)}
              | {16'd0, tdsls_pkg::seg_split(units3)};

endmodule

[hw/rtl/tdsls_queue.sv]
`timescale 1ns / 1ps

`include "three_digit_segment_led_serializer_assert.svh"

module tdsls_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tdsls_pkg::WORD_W-1:0] in_word,
  output logic                         out_valid,
  input  logic                         pop,
  output logic [tdsls_pkg::WORD_W-1:0] out_word
);

  logic [tdsls_pkg::WORD_W-1:0] mem [tdsls_pkg::QUEUE_DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push;

  assign in_ready  = (count != 2'(tdsls_pkg::QUEUE_DEPTH));
  assign push      = in_valid && in_ready;
  assign out_valid = (count != 2'd0);
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_word;
  end

  `TDSLS_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= 2'(tdsls_pkg::QUEUE_DEPTH))
  `TDSLS_ASSERT_SAME(a_pop_nonempty, clk, rst, pop, count != 2'd0)

endmodule

[hw/rtl/tdsls_back.sv]
`timescale 1ns / 1ps

`include "three_digit_segment_led_serializer_assert.svh"

module tdsls_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         word_valid,
  input  logic [tdsls_pkg::WORD_W-1:0] word,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         serial_bit,
  output logic                         latch_now
);

  logic                          busy;
  logic [tdsls_pkg::CNT_W-1:0]   cnt;
  logic [tdsls_pkg::WORD_W-1:0]  shreg;
  logic                          xfer;
  logic                          last_xfer;

  assign xfer      = busy && out_ready;
  assign last_xfer = xfer && (cnt == tdsls_pkg::LAST_BIT);
  assign pop       = word_valid && (!busy || last_xfer);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else begin
      // count wraps to zero after the last bit, ready for the next word
      if (xfer) cnt <= cnt + 5'd1;
      if (pop) busy <= 1'b1;
      else if (last_xfer) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) shreg <= word;
    else if (xfer) shreg <= shreg >> 1;
  end

  assign out_valid  = busy;
  assign serial_bit = shreg[0];
  assign latch_now  = (cnt == tdsls_pkg::LAST_BIT);

  `TDSLS_ASSERT_NEXT(a_cnt_step, clk, rst, xfer, cnt == $past(cnt) + 5'd1)
  `TDSLS_ASSERT_SAME(a_idle_at_zero, clk, rst, !busy, cnt == 5'd0)

endmodule

[hw/rtl/three_digit_segment_led_serializer.sv]
`timescale 1ns / 1ps
// Three-digit seven-segment and LED bar serializer.
// Slave stream: one transaction carries a 16-bit display value and a 4-bit
// bar level. Master stream: 32 transactions per input, one bit each, bit 0
// of the 32-bit display word first; tlast marks the 32nd bit, after which
// the shift chain latch is pulsed.
// The front end splits the value into units, tens and hundreds (mod ten)
// with reciprocal multiplies over three registered stages, looks up the
// segment and bar patterns and hands the finished word to a two-entry queue.
// The back end shifts the word out one bit per cycle while the receiver
// accepts. An accepted input passes through the three front-end stages,
// a queue entry and the shift register before its first bit is valid.
// The one-bit output channel limits the rate; the front-end stages and
// the queue hold up to five items ahead of the shifter. Reset clears all
// valid bits, the queue and the bit counter; no output is valid afterwards.
// When the receiver stalls, the current bit holds, the queue and the
// front-end stages fill, then tready drops until the shifter frees a slot.

module three_digit_segment_led_serializer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [15:0] display_value, [19:16] bar_level, [23:20] zero
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [0] serial_bit, [7:1] zero
  output logic        m_axis_tlast   // latch_now
);

  logic                         f_valid, f_ready;
  logic [tdsls_pkg::WORD_W-1:0] f_word;
  logic                         q_valid, q_pop;
  logic [tdsls_pkg::WORD_W-1:0] q_word;
  logic                         serial_bit;

  // classify and encode: digits, patterns, word assembly
  tdsls_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_value   (s_axis_tdata[15:0]),
    .in_level   (s_axis_tdata[19:16]),
    .word_valid (f_valid),
    .word_ready (f_ready),
    .word       (f_word)
  );

  // decouple encoder from shifter so either side can stall alone
  tdsls_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_word   (f_word),
    .out_valid (q_valid),
    .pop       (q_pop),
    .out_word  (q_word)
  );

  // shift the word out LSB first, flag the latch bit
  tdsls_back u_back (
    .clk        (clk),
    .rst        (rst),
    .word_valid (q_valid),
    .word       (q_word),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .serial_bit (serial_bit),
    .latch_now  (m_axis_tlast)
  );

  assign m_axis_tdata = {7'd0, serial_bit};

endmodule
